### src/smma_pkg.sv
package smma_pkg;

    // Operation codes carried by a request.
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Error codes on a result.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_SHAPE = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam int          CFG_ADDR_W   = 5;
    localparam int          CFG_INDEX_W  = 3;
    localparam logic [2:0]  REG_A_ROWS   = 3'd0;
    localparam logic [2:0]  REG_A_COLS   = 3'd1;
    localparam logic [2:0]  REG_B_ROWS   = 3'd2;
    localparam logic [2:0]  REG_B_COLS   = 3'd3;
    localparam logic [2:0]  REG_MODE     = 3'd4;

    // Operation kinds after classification by the front part.
    localparam logic [1:0] KIND_WRITE_A = 2'd0;
    localparam logic [1:0] KIND_WRITE_B = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_COMPUTE = 2'd3;

    // Fraction bits of the Q16.16 format.
    localparam int FRAC_BITS = 16;

    // Width of a dimension count in a queue entry (holds up to 31).
    localparam int DIM_FIELD_W = 5;

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]         result_row;
        logic [1:0]         result_col;
        logic signed [31:0] result_value;
        logic               last;
        logic [1:0]         error_code;
    } result_t;

    typedef struct packed {
        logic [2:0] a_rows;
        logic [2:0] a_cols;
        logic [2:0] b_rows;
        logic [2:0] b_cols;
        logic       mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [1:0]             error_code;
        logic [1:0]             row;
        logic [1:0]             col;
        logic signed [31:0]     value;
        logic                   mode;
        logic [DIM_FIELD_W-1:0] out_rows;
        logic [DIM_FIELD_W-1:0] out_cols;
        logic [DIM_FIELD_W-1:0] inner;
    } entry_t;

endpackage

### src/smma_front.sv
module smma_front
    import smma_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  request_t request,
    input  cfg_t     cfg,
    input  logic     accept,
    output logic     push,
    output entry_t   entry
);

    // Clamp a dimension register into the range one to MAX_DIM.
    function automatic logic [DIM_FIELD_W-1:0] clamp_dim(input logic [2:0] d);
        logic [DIM_FIELD_W-1:0] r;
        if (d == 3'd0)
        begin
            r = DIM_FIELD_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DIM_FIELD_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_FIELD_W'(d);
        end
        return r;
    endfunction

    logic [DIM_FIELD_W-1:0] ar;
    logic [DIM_FIELD_W-1:0] ac;
    logic [DIM_FIELD_W-1:0] br;
    logic [DIM_FIELD_W-1:0] bc;
    logic [DIM_FIELD_W-1:0] nr;
    logic [DIM_FIELD_W-1:0] nc;
    logic                   in_range;
    logic                   shape_ok;

    assign ar = clamp_dim(cfg.a_rows);
    assign ac = clamp_dim(cfg.a_cols);
    assign br = clamp_dim(cfg.b_rows);
    assign bc = clamp_dim(cfg.b_cols);

    // Bounds of the matrix that a write targets.
    assign nr = (request.operation == OP_WRITE_A) ? ar : br;
    assign nc = (request.operation == OP_WRITE_A) ? ac : bc;
    assign in_range = (DIM_FIELD_W'(request.row) < nr) && (DIM_FIELD_W'(request.col) < nc);

    // Add needs equal shapes; a product needs A's columns to match B's rows.
    assign shape_ok = cfg.mode ? (ac == br) : ((ar == br) && (ac == bc));

    // Classify the request into a queue entry.
    always_comb
    begin
        entry            = '0;
        entry.row        = request.row;
        entry.col        = request.col;
        entry.value      = request.value;
        entry.mode       = cfg.mode;
        entry.out_rows   = ar;
        entry.out_cols   = cfg.mode ? bc : ac;
        entry.inner      = cfg.mode ? ac : DIM_FIELD_W'(1);
        entry.error_code = ERR_NONE;
        push             = 1'b0;
        case (request.operation)
            OP_WRITE_A,
            OP_WRITE_B:
            begin
                push = accept;
                if (in_range)
                begin
                    entry.kind = (request.operation == OP_WRITE_A) ? KIND_WRITE_A
                                                                   : KIND_WRITE_B;
                end
                else
                begin
                    entry.kind       = KIND_ERROR;
                    entry.error_code = ERR_RANGE;
                end
            end
            OP_COMPUTE:
            begin
                push = accept;
                if (shape_ok)
                begin
                    entry.kind = KIND_COMPUTE;
                end
                else
                begin
                    entry.kind       = KIND_ERROR;
                    entry.error_code = ERR_SHAPE;
                    entry.row        = 2'd0;
                    entry.col        = 2'd0;
                end
            end
            default:
            begin
                // The unused operation code is dropped without a result.
                entry.kind = KIND_ERROR;
                push       = 1'b0;
            end
        endcase
    end

endmodule

### src/smma_queue.sv
module smma_queue
    import smma_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign empty   = (count_reg == QCNT_W'(0));
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/smma_back.sv
module smma_back
    import smma_pkg::*;
#(
    parameter int MAX_DIM    = 4,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  entry_t  head,
    output logic    pop,
    output logic    done,
    output result_t result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int EW    = ELEM_WIDTH;
    localparam int ACC_W = 2 * EW + FRAC_BITS + 2 + $clog2(MAX_DIM + 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W - EW + 1){1'b1}}, {(EW - 1){1'b0}}};

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Tags that travel with each multiply-accumulate step.
    typedef struct packed {
        logic [DW-1:0] i;
        logic [DW-1:0] j;
        logic          k_first;
        logic          k_last;
        logic          elem_last;
    } tag_t;

    logic signed [EW-1:0] mem_a [DEPTH];
    logic signed [EW-1:0] mem_b [DEPTH];

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 mode_reg;
    logic                 mode_next;
    logic [DW-1:0]        rows_reg;
    logic [DW-1:0]        rows_next;
    logic [DW-1:0]        cols_reg;
    logic [DW-1:0]        cols_next;
    logic [DW-1:0]        inner_reg;
    logic [DW-1:0]        inner_next;
    logic [DW-1:0]        i_reg;
    logic [DW-1:0]        i_next;
    logic [DW-1:0]        j_reg;
    logic [DW-1:0]        j_next;
    logic [DW-1:0]        k_reg;
    logic [DW-1:0]        k_next;

    logic                 issue;
    logic                 k_end;
    logic                 j_end;
    logic                 i_end;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [AW-1:0]        wr_addr;
    logic                 wr_a;
    logic                 wr_b;
    tag_t                 tag0;

    logic                 v1_reg;
    tag_t                 t1_reg;
    logic signed [EW-1:0] a_rd_reg;
    logic signed [EW-1:0] b_rd_reg;

    logic                 v2_reg;
    tag_t                 t2_reg;
    logic signed [ACC_W-1:0] p_reg;
    logic signed [2*EW-1:0]  prod;
    logic signed [EW:0]      sum;
    logic signed [ACC_W-1:0] p_next;

    logic                 v3_reg;
    tag_t                 t3_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] scaled;
    logic signed [EW-1:0]    sat_val;

    logic                 done_reg;
    logic                 done_next;
    result_t              result_reg;
    result_t              result_next;

    // Sequencer over rows, columns and the inner index.
    assign k_end = (k_reg == DW'(inner_reg - 1'b1));
    assign j_end = (j_reg == DW'(cols_reg - 1'b1));
    assign i_end = (i_reg == DW'(rows_reg - 1'b1));
    assign issue = (state_reg == ST_RUN);
    assign pop   = (state_reg == ST_IDLE) && !empty;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        inner_next  = inner_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        wr_a        = 1'b0;
        wr_b        = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    case (head.kind)
                        KIND_WRITE_A:
                        begin
                            wr_a = 1'b1;
                        end
                        KIND_WRITE_B:
                        begin
                            wr_b = 1'b1;
                        end
                        KIND_ERROR:
                        begin
                            done_next                = 1'b1;
                            result_next.result_row   = head.row;
                            result_next.result_col   = head.col;
                            result_next.result_value = '0;
                            result_next.last         = 1'b1;
                            result_next.error_code   = head.error_code;
                        end
                        default:
                        begin
                            mode_next  = head.mode;
                            rows_next  = head.out_rows[DW-1:0];
                            cols_next  = head.out_cols[DW-1:0];
                            inner_next = head.inner[DW-1:0];
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_RUN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (!k_end)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = '0;
                        if (!i_end)
                        begin
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished element leaves the accumulator; the pipeline is empty in idle.
        if (v3_reg && t3_reg.k_last)
        begin
            done_next                = 1'b1;
            result_next.result_row   = 2'(t3_reg.i);
            result_next.result_col   = 2'(t3_reg.j);
            result_next.result_value = 32'(sat_val);
            result_next.last         = t3_reg.elem_last;
            result_next.error_code   = ERR_NONE;
        end
    end

    // Memory addresses for the current step.
    assign rd_addr_a = mode_reg ? AW'(int'(i_reg) * MAX_DIM + int'(k_reg))
                                : AW'(int'(i_reg) * MAX_DIM + int'(j_reg));
    assign rd_addr_b = mode_reg ? AW'(int'(k_reg) * MAX_DIM + int'(j_reg))
                                : AW'(int'(i_reg) * MAX_DIM + int'(j_reg));
    assign wr_addr   = AW'(int'(head.row) * MAX_DIM + int'(head.col));

    assign tag0.i         = i_reg;
    assign tag0.j         = j_reg;
    assign tag0.k_first   = (k_reg == '0);
    assign tag0.k_last    = k_end;
    assign tag0.elem_last = k_end && j_end && i_end;

    // Matrix stores with registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= head.value[EW-1:0];
        end
        if (wr_b)
        begin
            mem_b[wr_addr] <= head.value[EW-1:0];
        end
        a_rd_reg <= mem_a[rd_addr_a];
        b_rd_reg <= mem_b[rd_addr_b];
    end

    // Product or sum, placed at the Q32.32 scale of a product.
    assign prod   = a_rd_reg * b_rd_reg;
    assign sum    = (EW + 1)'(a_rd_reg) + (EW + 1)'(b_rd_reg);
    assign p_next = mode_reg ? ACC_W'(prod) : (ACC_W'(sum) <<< FRAC_BITS);

    // Accumulation and scaling back to Q16.16 with saturation.
    assign acc_next = (t2_reg.k_first ? ACC_W'(0) : acc_reg) + p_reg;
    assign scaled   = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (scaled > SAT_HI)
        begin
            sat_val = SAT_HI[EW-1:0];
        end
        else if (scaled < SAT_LO)
        begin
            sat_val = SAT_LO[EW-1:0];
        end
        else
        begin
            sat_val = scaled[EW-1:0];
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        t1_reg     <= tag0;
        t2_reg     <= t1_reg;
        p_reg      <= p_next;
        t3_reg     <= t2_reg;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        mode_reg   <= mode_next;
        rows_reg   <= rows_next;
        cols_reg   <= cols_next;
        inner_reg  <= inner_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/small_matrix_multiply_add.sv
// Channel   Ports                                   Handshake
// request   start, busy, request                    taken when start is high and busy low
// result    done, result                            one cycle per result, cannot be held
// config    psel, penable, pwrite, paddr, pwdata,   APB write on access cycle, pready high
//           prdata, pready
//
// A write or an error request is handled in the idle state as it leaves the queue; an error
// result is on the ports in the next cycle. A product holds the back part while it steps
// over rows, columns and the inner index (an add rows and columns) and drains its pipeline.
// busy is high while the two-entry request queue is full. Reset is asynchronous and
// active low; it empties the queue and restores the configuration defaults, while the
// matrix stores stay undefined until written. The result receiver cannot stall.
module small_matrix_multiply_add
    import smma_pkg::*;
#(
    parameter int MAX_DIM    = 4,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  request_t              request,
    output logic                  done,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic                   cfg_write;
    logic                   accept;
    logic                   push;
    logic                   pop;
    logic                   empty;
    logic                   full;
    entry_t                 push_entry;
    entry_t                 head;

    assign pready    = 1'b1;
    assign cfg_index = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_A_ROWS: cfg_next.a_rows = pwdata[2:0];
                REG_A_COLS: cfg_next.a_cols = pwdata[2:0];
                REG_B_ROWS: cfg_next.b_rows = pwdata[2:0];
                REG_B_COLS: cfg_next.b_cols = pwdata[2:0];
                REG_MODE:   cfg_next.mode   = pwdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a_rows <= 3'd4;
            cfg_reg.a_cols <= 3'd4;
            cfg_reg.b_rows <= 3'd4;
            cfg_reg.b_cols <= 3'd4;
            cfg_reg.mode   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Configuration register reads.
    always_comb
    begin
        case (cfg_index)
            REG_A_ROWS: prdata = {29'd0, cfg_reg.a_rows};
            REG_A_COLS: prdata = {29'd0, cfg_reg.a_cols};
            REG_B_ROWS: prdata = {29'd0, cfg_reg.b_rows};
            REG_B_COLS: prdata = {29'd0, cfg_reg.b_cols};
            REG_MODE:   prdata = {31'd0, cfg_reg.mode};
            default:    prdata = 32'd0;
        endcase
    end

    assign busy   = full;
    assign accept = start && !busy;

    smma_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .request (request),
        .cfg     (cfg_reg),
        .accept  (accept),
        .push    (push),
        .entry   (push_entry)
    );

    smma_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    smma_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule
